>>> rtl/qtf_pkg.sv
// Package for the quad trapezoid fixup unit: coordinate widths, point and sign types,
// and the compare helpers used by the top level.
// No dependencies.
package qtf_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int NUM_PTS    = 4;
    localparam int NUM_TURNS  = 8;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic signed [PROD_BITS-1:0]  t_prod;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_pt;

    // sign of a corner turn: neg set for clockwise, zero for collinear
    typedef struct packed {
        logic neg;
        logic zero;
    } t_sgn;

    // p inside the bounding box of a-b, bounds inclusive
    function automatic logic qtf_in_box(t_pt a, t_pt b, t_pt p);
        logic in_x;
        logic in_y;
        in_x = ($signed(p.x) >= $signed(a.x) || $signed(p.x) >= $signed(b.x)) &&
               ($signed(p.x) <= $signed(a.x) || $signed(p.x) <= $signed(b.x));
        in_y = ($signed(p.y) >= $signed(a.y) || $signed(p.y) >= $signed(b.y)) &&
               ($signed(p.y) <= $signed(a.y) || $signed(p.y) <= $signed(b.y));
        return in_x && in_y;
    endfunction

    // a sorts after b: by y, then by x
    function automatic logic qtf_after(t_pt a, t_pt b);
        if (a.y != b.y) begin
            return $signed(a.y) > $signed(b.y);
        end
        return $signed(a.x) > $signed(b.x);
    endfunction

endpackage

>>> rtl/qtf_ifs.sv
// Valid/ready channel interfaces for the quad trapezoid fixup unit:
// the quad request channel and the result channel. Depends on qtf_pkg.
interface qtf_quad_if;
    import qtf_pkg::*;

    logic   valid;
    logic   ready;
    t_coord p0_x;
    t_coord p0_y;
    t_coord p1_x;
    t_coord p1_y;
    t_coord p2_x;
    t_coord p2_y;
    t_coord p3_x;
    t_coord p3_y;

    modport source (
        output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
        input  ready
    );
    modport sink (
        input  valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
        output ready
    );
endinterface

interface qtf_res_if;
    import qtf_pkg::*;

    logic   valid;
    logic   ready;
    t_coord q0_x;
    t_coord q0_y;
    t_coord q1_x;
    t_coord q1_y;
    t_coord q2_x;
    t_coord q2_y;
    t_coord q3_x;
    t_coord q3_y;
    logic   reordered;

    modport source (
        output valid, q0_x, q0_y, q1_x, q1_y, q2_x, q2_y, q3_x, q3_y, reordered,
        input  ready
    );
    modport sink (
        input  valid, q0_x, q0_y, q1_x, q1_y, q2_x, q2_y, q3_x, q3_y, reordered,
        output ready
    );
endinterface

>>> rtl/quad_trapezoid_fixup_unit.sv
// Quad trapezoid fixup unit: checks a quad for self-crossing and convexity and, when
// either fails, re-sorts the corners into top-left, top-right, bottom-right,
// bottom-left. One quad request per cycle unless a waiting result stalls the pipeline.
// The pipeline advances as one: a result waiting in the output register holds every
// stage and drops input ready. Depends on qtf_pkg, qtf_ifs and qtf_turn.
module quad_trapezoid_fixup_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    qtf_quad_if.sink  i_quad,
    qtf_res_if.source o_res
);
    import qtf_pkg::*;

    localparam int DEPTH = 5;

    // corner triples (a, b, c) of the eight turns; each also names one box test
    localparam int TRI_A [NUM_TURNS] = '{0, 0, 2, 2, 1, 1, 3, 3};
    localparam int TRI_B [NUM_TURNS] = '{1, 1, 3, 3, 2, 2, 0, 0};
    localparam int TRI_C [NUM_TURNS] = '{2, 3, 0, 1, 3, 0, 1, 2};

    logic             en;
    logic [DEPTH-1:0] r_vld;

    t_pt  w_pts [NUM_PTS];
    t_sgn w_sgn [NUM_TURNS];
    logic [NUM_TURNS-1:0] n_box;

    t_pt  r_s0_pts [NUM_PTS];
    t_pt  r_s1_raw [NUM_PTS];
    t_pt  r_s2_raw [NUM_PTS];
    t_pt  r_s3_raw [NUM_PTS];
    t_pt  r_s1_srt [NUM_PTS];
    t_pt  r_s2_srt [NUM_PTS];
    t_pt  r_s3_srt [NUM_PTS];
    t_pt  n_s1_srt [NUM_PTS];
    t_pt  n_s2_srt [NUM_PTS];
    t_pt  n_s3_srt [NUM_PTS];
    t_pt  n_q      [NUM_PTS];
    t_pt  r_q      [NUM_PTS];
    logic [NUM_TURNS-1:0] r_s0_box, r_s1_box, r_s2_box;
    logic r_s3_fix, n_s3_fix, r_fix;

    assign en           = !r_vld[DEPTH-1] || o_res.ready;
    assign i_quad.ready = en;

    assign w_pts[0] = '{x: i_quad.p0_x, y: i_quad.p0_y};
    assign w_pts[1] = '{x: i_quad.p1_x, y: i_quad.p1_y};
    assign w_pts[2] = '{x: i_quad.p2_x, y: i_quad.p2_y};
    assign w_pts[3] = '{x: i_quad.p3_x, y: i_quad.p3_y};

    for (genvar k = 0; k < NUM_TURNS; k++) begin : g_turn
        qtf_turn u_turn (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (w_pts[TRI_A[k]]),
            .i_b   (w_pts[TRI_B[k]]),
            .i_c   (w_pts[TRI_C[k]]),
            .o_sgn (w_sgn[k])
        );
        assign n_box[k] = qtf_in_box(w_pts[TRI_A[k]], w_pts[TRI_B[k]], w_pts[TRI_C[k]]);
    end

    // sorting network, one layer per stage
    always_comb begin
        n_s1_srt = r_s0_pts;
        if (qtf_after(r_s0_pts[0], r_s0_pts[1])) begin
            n_s1_srt[0] = r_s0_pts[1];
            n_s1_srt[1] = r_s0_pts[0];
        end
        if (qtf_after(r_s0_pts[2], r_s0_pts[3])) begin
            n_s1_srt[2] = r_s0_pts[3];
            n_s1_srt[3] = r_s0_pts[2];
        end

        n_s2_srt = r_s1_srt;
        if (qtf_after(r_s1_srt[0], r_s1_srt[2])) begin
            n_s2_srt[0] = r_s1_srt[2];
            n_s2_srt[2] = r_s1_srt[0];
        end
        if (qtf_after(r_s1_srt[1], r_s1_srt[3])) begin
            n_s2_srt[1] = r_s1_srt[3];
            n_s2_srt[3] = r_s1_srt[1];
        end

        n_s3_srt = r_s2_srt;
        if (qtf_after(r_s2_srt[1], r_s2_srt[2])) begin
            n_s3_srt[1] = r_s2_srt[2];
            n_s3_srt[2] = r_s2_srt[1];
        end
    end

    // crossing and convexity; turn signs line up with stage 2
    always_comb begin
        logic prop_a, prop_b, touch_a, touch_b, any_pos, any_neg;
        logic [NUM_TURNS-1:0] zero;
        for (int k = 0; k < NUM_TURNS; k++) begin
            zero[k] = w_sgn[k].zero;
        end
        prop_a  = !zero[0] && !zero[1] && (w_sgn[0].neg ^ w_sgn[1].neg) &&
                  !zero[2] && !zero[3] && (w_sgn[2].neg ^ w_sgn[3].neg);
        prop_b  = !zero[4] && !zero[5] && (w_sgn[4].neg ^ w_sgn[5].neg) &&
                  !zero[6] && !zero[7] && (w_sgn[6].neg ^ w_sgn[7].neg);
        touch_a = |(zero[3:0] & r_s2_box[3:0]);
        touch_b = |(zero[7:4] & r_s2_box[7:4]);
        // corner turns are triples 0, 4, 2 and 6
        any_neg = w_sgn[0].neg || w_sgn[4].neg || w_sgn[2].neg || w_sgn[6].neg;
        any_pos = (!w_sgn[0].neg && !zero[0]) || (!w_sgn[4].neg && !zero[4]) ||
                  (!w_sgn[2].neg && !zero[2]) || (!w_sgn[6].neg && !zero[6]);
        n_s3_fix = prop_a || prop_b || touch_a || touch_b || (any_pos && any_neg);
    end

    // last layer: order each pair by x, then pick the result
    always_comb begin
        t_pt s0, s1, s2, s3;
        s0 = r_s3_srt[0];
        s1 = r_s3_srt[1];
        s2 = r_s3_srt[2];
        s3 = r_s3_srt[3];
        if ($signed(r_s3_srt[0].x) > $signed(r_s3_srt[1].x)) begin
            s0 = r_s3_srt[1];
            s1 = r_s3_srt[0];
        end
        if ($signed(r_s3_srt[2].x) > $signed(r_s3_srt[3].x)) begin
            s2 = r_s3_srt[3];
            s3 = r_s3_srt[2];
        end
        if (r_s3_fix) begin
            n_q[0] = s0;
            n_q[1] = s1;
            n_q[2] = s3;
            n_q[3] = s2;
        end else begin
            n_q = r_s3_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_quad.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_pts <= w_pts;
            r_s0_box <= n_box;
            r_s1_raw <= r_s0_pts;
            r_s1_srt <= n_s1_srt;
            r_s1_box <= r_s0_box;
            r_s2_raw <= r_s1_raw;
            r_s2_srt <= n_s2_srt;
            r_s2_box <= r_s1_box;
            r_s3_raw <= r_s2_raw;
            r_s3_srt <= n_s3_srt;
            r_s3_fix <= n_s3_fix;
            r_q      <= n_q;
            r_fix    <= r_s3_fix;
        end
    end

    assign o_res.valid     = r_vld[DEPTH-1];
    assign o_res.q0_x      = r_q[0].x;
    assign o_res.q0_y      = r_q[0].y;
    assign o_res.q1_x      = r_q[1].x;
    assign o_res.q1_y      = r_q[1].y;
    assign o_res.q2_x      = r_q[2].x;
    assign o_res.q2_y      = r_q[2].y;
    assign o_res.q3_x      = r_q[3].x;
    assign o_res.q3_y      = r_q[3].y;
    assign o_res.reordered = r_fix;

`ifndef SYNTHESIS
    // input held back only by a result that is waiting
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_quad.ready |-> (o_res.valid && !o_res.ready))
        else $error("input stalled without a waiting result");

    // a repaired quad comes out in trapezoid order
    a_repair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.reordered) |->
            ($signed(o_res.q0_x) <= $signed(o_res.q1_x) &&
             $signed(o_res.q3_x) <= $signed(o_res.q2_x) &&
             $signed(o_res.q0_y) <= $signed(o_res.q3_y) &&
             $signed(o_res.q1_y) <= $signed(o_res.q2_y)))
        else $error("repaired corners out of order");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_res.valid && r_vld == '0))
        else $error("pipeline not empty after reset");

    // a request that is never stalled reaches the output register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_quad.valid && i_quad.ready) ##1 en ##1 en ##1 en ##1 en |=> o_res.valid)
        else $error("request lost in the pipeline");
`endif

endmodule

>>> rtl/qtf_turn.sv
// Three-stage turn unit: sign of the cross product (b - a) x (c - a), exact.
// Stages: edge differences, two products, difference and sign. Depends on qtf_pkg.
module qtf_turn (
    input  logic         i_clk,
    input  logic         i_en,
    input  qtf_pkg::t_pt i_a,
    input  qtf_pkg::t_pt i_b,
    input  qtf_pkg::t_pt i_c,
    output qtf_pkg::t_sgn o_sgn
);
    import qtf_pkg::*;

    t_diff r_dx1, r_dy1, r_dx2, r_dy2;
    t_diff n_dx1, n_dy1, n_dx2, n_dy2;
    t_prod r_p, r_q;
    logic signed [PROD_BITS:0] n_det;
    t_sgn  r_sgn;

    always_comb begin
        n_dx1 = {i_b.x[COORD_BITS-1], i_b.x} - {i_a.x[COORD_BITS-1], i_a.x};
        n_dy1 = {i_b.y[COORD_BITS-1], i_b.y} - {i_a.y[COORD_BITS-1], i_a.y};
        n_dx2 = {i_c.x[COORD_BITS-1], i_c.x} - {i_a.x[COORD_BITS-1], i_a.x};
        n_dy2 = {i_c.y[COORD_BITS-1], i_c.y} - {i_a.y[COORD_BITS-1], i_a.y};
        n_det = {r_p[PROD_BITS-1], r_p} - {r_q[PROD_BITS-1], r_q};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx1     <= n_dx1;
            r_dy1     <= n_dy1;
            r_dx2     <= n_dx2;
            r_dy2     <= n_dy2;
            r_p       <= r_dx1 * r_dy2;
            r_q       <= r_dy1 * r_dx2;
            r_sgn.neg  <= n_det[PROD_BITS];
            r_sgn.zero <= (n_det == '0);
        end
    end

    assign o_sgn = r_sgn;

endmodule

>>> tb/quad_trapezoid_fixup_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for quad_trapezoid_fixup_unit: directed quads, then random quads,
// with random stalls on both channels. Depends on qtf_pkg, qtf_ifs and the unit itself.
module quad_trapezoid_fixup_unit_tb;
    import qtf_pkg::*;

    typedef struct {
        longint x;
        longint y;
    } t_ipt;

    typedef struct {
        t_pt c [NUM_PTS];
    } t_quad;

    typedef struct {
        t_pt  c [NUM_PTS];
        logic reordered;
    } t_fixed_quad;

    localparam int DIR_ROWS     = 18;
    localparam int DIR_COLS     = 18;
    localparam int RAND_ITEMS   = 1530;
    localparam int CALM_ITEMS   = 200;
    localparam int HOLD_AT      = 600;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;

    logic i_clk;
    logic i_rst_n;

    qtf_quad_if quad_if ();
    qtf_res_if  res_if ();

    quad_trapezoid_fixup_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_quad  (quad_if),
        .o_res   (res_if)
    );

    t_fixed_quad fixed_q [$];
    int          err_count = 0;
    bit          calm      = 1'b0;
    bit          hold_req  = 1'b0;
    bit          hold_done = 1'b0;

    // corners p0..p3 (x, y), typed flag, then q0..q3 (x, y) and reordered
    int dir_tab [DIR_ROWS][DIR_COLS] = '{
        '{0, 0, 10, 0, 10, 10, 0, 10,  1,  0, 0, 10, 0, 10, 10, 0, 10, 0},
        '{0, 0, 10, 10, 10, 0, 0, 10,  1,  0, 0, 10, 0, 10, 10, 0, 10, 1},
        '{0, 0, 0, 0, 0, 0, 0, 0,      1,  0, 0, 0, 0, 0, 0, 0, 0, 1},
        '{-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767,  1,
          -32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767, 0},
        '{-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767,  1,
          -32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767, 1},
        '{0, 0, 0, 10, 10, 10, 10, 0,     0,  0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 10, 5, 0, 10, 3, 5,       0,  0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 5, 0, 10, 0, 5, 5,        0,  0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 1, 1, 1, 5, 5, 0, 5,         0,  0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 10, 0, 5, 0, 5, 10,       0,  0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{7, -3, 7, -3, 7, -3, 7, -3,     0,  0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 5, 3, 5, 9, 5, 1, 5,         0,  0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, -32768, 32767, 0, 0, 32767, -32768, 0,  0,  0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{-32768, -32768, 32767, -32768, 0, 0, 32767, 32767,  0,
          0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{-1, -1, 32767, -32768, -32768, 32767, 0, -1,  0,  0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{5, 5, 5, 5, 2, 9, 8, 9,         0,  0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 10, 0, 10, 10, 5, 5,      0,  0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{-32768, 32767, 32767, -32768, 32767, 32766, -32768, -32768,  0,
          0, 0, 0, 0, 0, 0, 0, 0, 0}
    };

    // --- predictor: exact integer geometry on 64-bit values ---

    function automatic int corner_turn(t_ipt a, t_ipt b, t_ipt c);
        longint lhs;
        longint rhs;
        lhs = (b.x - a.x) * (c.y - a.y);
        rhs = (b.y - a.y) * (c.x - a.x);
        return (lhs > rhs) ? 1 : ((lhs < rhs) ? -1 : 0);
    endfunction

    function automatic bit in_span(t_ipt a, t_ipt b, t_ipt p);
        longint lx;
        longint hx;
        longint ly;
        longint hy;
        lx = (a.x < b.x) ? a.x : b.x;
        hx = (a.x < b.x) ? b.x : a.x;
        ly = (a.y < b.y) ? a.y : b.y;
        hy = (a.y < b.y) ? b.y : a.y;
        return p.x >= lx && p.x <= hx && p.y >= ly && p.y <= hy;
    endfunction

    // segment a-b against c-d: proper crossing or an inclusive touch
    function automatic bit edges_meet(t_ipt a, t_ipt b, t_ipt c, t_ipt d);
        int s1;
        int s2;
        int s3;
        int s4;
        s1 = corner_turn(a, b, c);
        s2 = corner_turn(a, b, d);
        s3 = corner_turn(c, d, a);
        s4 = corner_turn(c, d, b);
        if (s1 * s2 < 0 && s3 * s4 < 0) begin
            return 1'b1;
        end
        return (s1 == 0 && in_span(a, b, c)) || (s2 == 0 && in_span(a, b, d)) ||
               (s3 == 0 && in_span(c, d, a)) || (s4 == 0 && in_span(c, d, b));
    endfunction

    // collinear corners are skipped
    function automatic bit turns_agree(t_ipt p [NUM_PTS]);
        int first;
        int s;
        first = 0;
        for (int i = 0; i < NUM_PTS; i++) begin
            s = corner_turn(p[i], p[(i + 1) % NUM_PTS], p[(i + 2) % NUM_PTS]);
            if (s != 0) begin
                if (first == 0) begin
                    first = s;
                end else if (first != s) begin
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic bit sorts_later(t_ipt a, t_ipt b);
        if (a.y != b.y) begin
            return a.y > b.y;
        end
        return a.x > b.x;
    endfunction

    function automatic t_fixed_quad fix_quad(t_quad q);
        t_ipt        p [NUM_PTS];
        t_ipt        s [NUM_PTS];
        t_ipt        tmp;
        t_fixed_quad r;
        bit          fix;
        int          lo_idx [5];
        int          hi_idx [5];
        lo_idx = '{0, 2, 0, 1, 1};
        hi_idx = '{1, 3, 2, 3, 2};
        for (int i = 0; i < NUM_PTS; i++) begin
            p[i].x = longint'($signed(q.c[i].x));
            p[i].y = longint'($signed(q.c[i].y));
        end
        fix = edges_meet(p[0], p[1], p[2], p[3]) || edges_meet(p[1], p[2], p[3], p[0]) ||
              !turns_agree(p);
        s = p;
        if (fix) begin
            for (int k = 0; k < 5; k++) begin
                if (sorts_later(s[lo_idx[k]], s[hi_idx[k]])) begin
                    tmp           = s[lo_idx[k]];
                    s[lo_idx[k]]  = s[hi_idx[k]];
                    s[hi_idx[k]]  = tmp;
                end
            end
            for (int k = 0; k < NUM_PTS; k += 2) begin
                if (s[k].x > s[k + 1].x) begin
                    tmp      = s[k];
                    s[k]     = s[k + 1];
                    s[k + 1] = tmp;
                end
            end
            // bottom pair comes out right then left
            tmp  = s[2];
            s[2] = s[3];
            s[3] = tmp;
        end
        for (int i = 0; i < NUM_PTS; i++) begin
            r.c[i].x = t_coord'(s[i].x);
            r.c[i].y = t_coord'(s[i].y);
        end
        r.reordered = fix;
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    // --- quad request side ---

    task automatic send_quad(t_quad q, t_fixed_quad want);
        if (!calm && $urandom_range(3) == 0) begin
            quad_if.valid <= 1'b0;
            repeat ($urandom_range(7, 1)) @(posedge i_clk);
        end
        quad_if.valid <= 1'b1;
        quad_if.p0_x  <= q.c[0].x;
        quad_if.p0_y  <= q.c[0].y;
        quad_if.p1_x  <= q.c[1].x;
        quad_if.p1_y  <= q.c[1].y;
        quad_if.p2_x  <= q.c[2].x;
        quad_if.p2_y  <= q.c[2].y;
        quad_if.p3_x  <= q.c[3].x;
        quad_if.p3_y  <= q.c[3].y;
        @(posedge i_clk);
        while (!quad_if.ready) @(posedge i_clk);
        fixed_q = {fixed_q, want};
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin : stim
        t_quad       q;
        t_fixed_quad want;
        t_pt         k [NUM_PTS];
        t_pt         tmp;
        int          cx;
        int          cy;
        int          rad;
        int          rot;
        int          kind;
        int          bx;
        int          by;
        bit          rev;

        i_rst_n       <= 1'b0;
        quad_if.valid <= 1'b0;
        quad_if.p0_x  <= '0;
        quad_if.p0_y  <= '0;
        quad_if.p1_x  <= '0;
        quad_if.p1_y  <= '0;
        quad_if.p2_x  <= '0;
        quad_if.p2_y  <= '0;
        quad_if.p3_x  <= '0;
        quad_if.p3_y  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            for (int i = 0; i < NUM_PTS; i++) begin
                q.c[i].x    = t_coord'(dir_tab[r][2 * i]);
                q.c[i].y    = t_coord'(dir_tab[r][2 * i + 1]);
                want.c[i].x = t_coord'(dir_tab[r][9 + 2 * i]);
                want.c[i].y = t_coord'(dir_tab[r][10 + 2 * i]);
            end
            want.reordered = dir_tab[r][DIR_COLS - 1][0];
            if (dir_tab[r][8] == 0) begin
                want = fix_quad(q);
            end
            send_quad(q, want);
        end

        for (int n = 0; n < RAND_ITEMS; n++) begin
            calm = (n >= RAND_ITEMS - CALM_ITEMS);
            if (n == HOLD_AT) begin
                hold_req = 1'b1;
            end
            kind = $urandom_range(99);
            if (kind < 50) begin
                // kite around a centre: convex in any rotation or direction
                cx = int'($urandom_range(32000)) - 16000;
                cy = int'($urandom_range(32000)) - 16000;
                for (int i = 0; i < NUM_PTS; i++) begin
                    rad = ($urandom_range(1) == 1) ? int'($urandom_range(15, 1))
                                                    : int'($urandom_range(16000, 1));
                    k[i].x = t_coord'((i == 0) ? cx - rad : ((i == 2) ? cx + rad : cx));
                    k[i].y = t_coord'((i == 1) ? cy - rad : ((i == 3) ? cy + rad : cy));
                end
                rot = $urandom_range(3);
                rev = 1'($urandom_range(1));
                for (int i = 0; i < NUM_PTS; i++) begin
                    q.c[i] = k[rev ? ((rot - i) & 3) : ((rot + i) & 3)];
                end
                if (kind >= 30) begin
                    // swapping neighbours turns it into a bowtie
                    tmp    = q.c[1];
                    q.c[1] = q.c[2];
                    q.c[2] = tmp;
                end
            end else if (kind < 70) begin
                // tight grid: repeats, collinear corners and touches
                bx = int'($urandom_range(65532)) - 32768;
                by = int'($urandom_range(65532)) - 32768;
                for (int i = 0; i < NUM_PTS; i++) begin
                    q.c[i].x = t_coord'(bx + int'($urandom_range(3)));
                    q.c[i].y = t_coord'(by + int'($urandom_range(3)));
                end
            end else begin
                for (int i = 0; i < NUM_PTS; i++) begin
                    q.c[i].x = t_coord'($urandom);
                    q.c[i].y = t_coord'($urandom);
                end
            end
            send_quad(q, fix_quad(q));
        end
        quad_if.valid <= 1'b0;

        while (fixed_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // --- result side: random back-pressure, one long hold-off ---

    initial begin : res_sink
        res_if.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(3) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(7, 1)) @(posedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                repeat ($urandom_range(8, 1)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : res_mon
        t_fixed_quad want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (fixed_q.size() == 0) begin
                $error("result request with no quad outstanding");
                err_count++;
            end else begin
                want = fixed_q.pop_front();
                check_field("q0_x", want.c[0].x, res_if.q0_x);
                check_field("q0_y", want.c[0].y, res_if.q0_y);
                check_field("q1_x", want.c[1].x, res_if.q1_x);
                check_field("q1_y", want.c[1].y, res_if.q1_y);
                check_field("q2_x", want.c[2].x, res_if.q2_x);
                check_field("q2_y", want.c[2].y, res_if.q2_y);
                check_field("q3_x", want.c[3].x, res_if.q3_x);
                check_field("q3_y", want.c[3].y, res_if.q3_y);
                check_field("reordered", int'(want.reordered), int'(res_if.reordered));
            end
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
